@@ design/wsip_pkg.sv @@
// wsip_pkg: shared types, constants and helpers for the wide string parser
// no dependencies; imported by every module of the parser
package wsip_pkg;

  localparam int CHAR_W      = 16;
  localparam int VALUE_W     = 32;
  localparam int BASE_W      = 5;
  localparam int DIGIT_W     = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
  localparam logic [BASE_W-1:0] BASE_2    = 5'd2;
  localparam logic [BASE_W-1:0] BASE_8    = 5'd8;
  localparam logic [BASE_W-1:0] BASE_10   = 5'd10;
  localparam logic [BASE_W-1:0] BASE_16   = 5'd16;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef enum logic [3:0] {
    PH_SIGN    = 4'b0001,
    PH_PREFIX  = 4'b0010,
    PH_DIGITS  = 4'b0100,
    PH_STOPPED = 4'b1000
  } phase_e;

  // one classified character as it travels from front to back
  typedef struct packed {
    logic                 empty;
    logic                 last;
    logic                 is_nul;
    logic                 is_sign;
    logic                 is_minus;
    logic                 pfx_hit;
    logic [BASE_W-1:0]    pfx_base;
    logic                 is_digit;
    logic [DIGIT_W-1:0]   digit;
  } char_item_t;

  function automatic logic base_usable(input logic [BASE_W-1:0] b);
    return b inside {BASE_2, BASE_8, BASE_10, BASE_16};
  endfunction

  // acc * base for the four usable bases, shift-add only
  function automatic logic [VALUE_W-1:0] scale_acc(input logic [VALUE_W-1:0] acc,
                                                   input logic [BASE_W-1:0]  b);
    logic [VALUE_W-1:0] r;
    case (b)
      BASE_2:  r = acc << 1;
      BASE_8:  r = acc << 3;
      BASE_10: r = (acc << 3) + (acc << 1);
      BASE_16: r = acc << 4;
      default: r = acc; // unusable base, value is discarded anyway
    endcase
    return r;
  endfunction

endpackage

@@ design/wide_string_to_integer_parser_unit.sv @@
// wide_string_to_integer_parser_unit: top level of the wide string parser
// depends on wsip_pkg, wsip_front, wsip_queue, wsip_back
//
// Parses a stream of wide characters (one per transaction, low byte examined but all
// bits for NUL, letters case-folded) into a 32-bit value with optional sign and, when the
// configured base is 0, a 'x'/'o'/'b' prefix. tlast ends a string and produces
// one result transaction; tuser marks an empty step that carries no character.
// Throughput is one character per clock unless the queue fills: the front classifies
// the character, a two-entry queue decouples it from the back, whose accumulator update
// is a single shift-add per cycle. A last character passes the queue, then the result
// register. The base register must be written only while the block is idle.
module wide_string_to_integer_parser_unit import wsip_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [BASE_W-1:0]   cfg_wdata_i,    // number_base
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [CHAR_W-1:0]   s_axis_tdata_i, // [15:0] character
  input  logic                s_axis_tuser_i, // [0] empty_string
  input  logic                s_axis_tlast_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [VALUE_W-1:0]  m_axis_tdata_o, // [31:0] value
  output logic                m_axis_tuser_o  // [0] status
);

  logic [BASE_W-1:0] number_base_q;
  char_item_t        front_item;
  char_item_t        head_item;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              head_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BASE_AUTO;
    end else if (cfg_we_i) begin
      number_base_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready_o = !q_full;
  assign q_push          = s_axis_tvalid_i && !q_full;

  wsip_front u_front (
    .character_i (s_axis_tdata_i),
    .empty_i     (s_axis_tuser_i),
    .last_i      (s_axis_tlast_i),
    .item_o      (front_item)
  );

  wsip_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_item_i  (front_item),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  wsip_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .number_base_i (number_base_q),
    .head_valid_i  (head_valid),
    .head_item_i   (head_item),
    .pop_o         (q_pop),
    .res_valid_o   (m_axis_tvalid_o),
    .res_ready_i   (m_axis_tready_i),
    .value_o       (m_axis_tdata_o),
    .status_o      (m_axis_tuser_o)
  );

endmodule

@@ design/wsip_front.sv @@
// wsip_front: classifies one incoming character (case fold, sign, prefix, digit)
// depends on wsip_pkg
module wsip_front import wsip_pkg::*; (
  input  logic [CHAR_W-1:0] character_i,
  input  logic              empty_i,
  input  logic              last_i,
  output char_item_t        item_o
);

  logic [7:0] c;

  always_comb begin
    c = character_i[7:0];
    if (c inside {[CH_UA:CH_UZ]}) begin
      c = c + CASE_OFS;
    end
  end

  always_comb begin
    item_o          = '0;
    item_o.empty    = empty_i;
    item_o.last     = last_i;
    item_o.is_nul   = (character_i == '0);
    item_o.is_sign  = c inside {CH_PLUS, CH_MINUS};
    item_o.is_minus = (c == CH_MINUS);
    item_o.pfx_hit  = c inside {CH_X, CH_O, CH_B};
    item_o.pfx_base = (c == CH_X) ? BASE_16 : (c == CH_O) ? BASE_8 : BASE_2;
    if (c inside {[CH_0:CH_9]}) begin
      item_o.is_digit = 1'b1;
      item_o.digit    = DIGIT_W'(c - CH_0);
    end else if (c inside {[CH_A:CH_F]}) begin
      item_o.is_digit = 1'b1;
      item_o.digit    = DIGIT_W'(c - CH_A + 8'd10);
    end
  end

endmodule

@@ design/wsip_queue.sv @@
// wsip_queue: short fifo of classified characters between front and back
// depends on wsip_pkg
module wsip_queue import wsip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  char_item_t push_item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       head_valid_o,
  output char_item_t head_item_o
);

  char_item_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

@@ design/wsip_back.sv @@
// wsip_back: parse state machine, accumulator and result register
// depends on wsip_pkg
module wsip_back import wsip_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [BASE_W-1:0]  number_base_i,
  input  logic               head_valid_i,
  input  char_item_t         head_item_i,
  output logic               pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [VALUE_W-1:0] value_o,
  output logic               status_o
);

  phase_e             phase_q, phase_d;
  logic [BASE_W-1:0]  base_q, base_d;
  logic               neg_q, neg_d;
  logic [VALUE_W-1:0] acc_q, acc_d;

  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_acc_q;
  logic               out_neg_q;
  logic               out_status_q;

  logic               emit;
  logic               invalid;

  // a last item needs the result slot free or draining this cycle
  assign pop_o = head_valid_i &&
                 (!head_item_i.last || !out_valid_q || res_ready_i);
  assign emit  = pop_o && head_item_i.last;

  always_comb begin
    phase_e ph;
    logic   done;
    phase_d = phase_q;
    base_d  = base_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    ph      = phase_q;
    done    = 1'b0;
    if (pop_o && !head_item_i.empty) begin
      if (ph == PH_SIGN) begin
        base_d = number_base_i;
        neg_d  = 1'b0;
        acc_d  = '0;
        ph     = (number_base_i == BASE_AUTO) ? PH_PREFIX : PH_DIGITS;
        if (head_item_i.is_sign) begin
          neg_d   = head_item_i.is_minus;
          phase_d = ph;
          done    = 1'b1;
        end
      end
      if (!done && ph == PH_PREFIX) begin
        if (head_item_i.is_nul) begin
          phase_d = PH_STOPPED;
          done    = 1'b1;
        end else if (head_item_i.pfx_hit) begin
          base_d  = head_item_i.pfx_base;
          phase_d = PH_DIGITS;
          done    = 1'b1;
        end else begin
          base_d = BASE_10;
          ph     = PH_DIGITS;
        end
      end
      if (!done) begin
        if (ph == PH_DIGITS) begin
          if (head_item_i.is_nul || !head_item_i.is_digit ||
              BASE_W'(head_item_i.digit) >= base_d) begin
            phase_d = PH_STOPPED;
          end else begin
            acc_d   = scale_acc(acc_d, base_d) + VALUE_W'(head_item_i.digit);
            phase_d = PH_DIGITS;
          end
        end else begin
          phase_d = PH_STOPPED;
        end
      end
    end
  end

  assign invalid = (phase_d != PH_SIGN) && !base_usable(base_d);

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIGN;
      base_q      <= '0;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (emit) begin
        phase_q <= PH_SIGN;
        base_q  <= '0;
        neg_q   <= 1'b0;
        acc_q   <= '0;
      end else begin
        phase_q <= phase_d;
        base_q  <= base_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
      end
    end
  end

  // nothing parsed or unusable base gives zero; negation happens after the register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_acc_q    <= (phase_d == PH_SIGN || invalid) ? '0 : acc_d;
      out_neg_q    <= neg_d;
      out_status_q <= invalid ? STATUS_INVALID : STATUS_OK;
    end
  end

  assign res_valid_o = out_valid_q;
  assign value_o     = out_neg_q ? (VALUE_W'(0) - out_acc_q) : out_acc_q;
  assign status_o    = out_status_q;

endmodule

@@ sim/wsip_parse_checker.sv @@
// wsip_parse_checker: predicts the parsed value and status of every string
// depends on wsip_pkg; watches the config write, input and result streams
module wsip_parse_checker
  import wsip_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [BASE_W-1:0]  cfg_wdata_i,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  input  logic [CHAR_W-1:0]  s_axis_tdata_i,
  input  logic               s_axis_tuser_i,
  input  logic               s_axis_tlast_i,
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  input  logic [VALUE_W-1:0] m_axis_tdata_i,
  input  logic               m_axis_tuser_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               status;
  } parse_result_t;

  parse_result_t      expected_results[$];
  int                 mismatches;

  // shadow of the base register and of the string being scanned
  logic [BASE_W-1:0]  base_reg;
  phase_e             scan_phase;
  logic [BASE_W-1:0]  cur_base;
  logic               minus_seen;
  logic [VALUE_W-1:0] acc;

  function automatic void clear_scan();
    scan_phase = PH_SIGN;
    cur_base   = '0;
    minus_seen = 1'b0;
    acc        = '0;
  endfunction

  function automatic void scan_char(input logic [CHAR_W-1:0] ch);
    logic [7:0]        c;
    phase_e            nxt;
    logic [BASE_W-1:0] dig;
    c = ch[7:0];
    if (c >= CH_UA && c <= CH_UZ) begin
      c = c + CASE_OFS;
    end
    nxt = scan_phase;
    // first character latches the base and may be a sign
    if (nxt == PH_SIGN) begin
      cur_base   = base_reg;
      minus_seen = 1'b0;
      acc        = '0;
      nxt        = (base_reg == BASE_AUTO) ? PH_PREFIX : PH_DIGITS;
      if (c == CH_MINUS || c == CH_PLUS) begin
        minus_seen = (c == CH_MINUS);
        scan_phase = nxt;
        return;
      end
    end
    if (nxt == PH_PREFIX) begin
      if (ch == '0) begin
        scan_phase = PH_STOPPED;
        return;
      end
      if (c == CH_X || c == CH_O || c == CH_B) begin
        cur_base   = (c == CH_X) ? BASE_16 : (c == CH_O) ? BASE_8 : BASE_2;
        scan_phase = PH_DIGITS;
        return;
      end
      // no prefix letter: decimal, and this character is a digit candidate
      cur_base = BASE_10;
      nxt      = PH_DIGITS;
    end
    if (nxt == PH_DIGITS) begin
      if (ch == '0) begin
        scan_phase = PH_STOPPED;
        return;
      end
      if (c >= CH_0 && c <= CH_9) begin
        dig = BASE_W'(c - CH_0);
      end else if (c >= CH_A && c <= CH_F) begin
        dig = BASE_W'(c - CH_A + 8'd10);
      end else begin
        scan_phase = PH_STOPPED;
        return;
      end
      if (dig >= cur_base) begin
        scan_phase = PH_STOPPED;
        return;
      end
      acc        = acc * cur_base + dig;
      scan_phase = PH_DIGITS;
      return;
    end
    scan_phase = PH_STOPPED;
  endfunction

  function automatic parse_result_t finish_string();
    parse_result_t r;
    r.value  = '0;
    r.status = STATUS_OK;
    if (scan_phase != PH_SIGN) begin
      if (cur_base == BASE_2 || cur_base == BASE_8 || cur_base == BASE_10 ||
          cur_base == BASE_16) begin
        r.value = minus_seen ? VALUE_W'(0) - acc : acc;
      end else begin
        r.status = STATUS_INVALID;
      end
    end
    clear_scan();
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t want;
    if (!rst_ni) begin
      base_reg = BASE_AUTO;
      clear_scan();
      expected_results.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        base_reg = cfg_wdata_i;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result transaction: expected none, got value %h status %b",
                   $time, m_axis_tdata_i, m_axis_tuser_i);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata_i !== want.value) begin
            mismatches++;
            $display("%0t: value mismatch: expected %h, got %h",
                     $time, want.value, m_axis_tdata_i);
          end
          if (m_axis_tuser_i !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %b, got %b",
                     $time, want.status, m_axis_tuser_i);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (!s_axis_tuser_i) begin
          scan_char(s_axis_tdata_i);
        end
        if (s_axis_tlast_i) begin
          expected_results.push_back(finish_string());
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_results.size();
    end
  end

endmodule

@@ sim/tb_wide_string_to_integer_parser_unit.sv @@
// tb_wide_string_to_integer_parser_unit: stimulus and verdict for the parser
// depends on wsip_pkg, wide_string_to_integer_parser_unit and wsip_parse_checker
module tb_wide_string_to_integer_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import wsip_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int SEG_ITEMS   = 140;
  localparam int NUM_SEGS    = 12;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [BASE_W-1:0]  cfg_wdata  = '0;
  logic               s_tvalid   = 1'b0;
  logic               s_tready;
  logic [CHAR_W-1:0]  s_tdata    = '0;
  logic               s_tuser    = 1'b0;
  logic               s_tlast    = 1'b0;
  logic               m_tvalid;
  logic               m_tready   = 1'b0;
  logic [VALUE_W-1:0] m_tdata;
  logic               m_tuser;

  int fail_count;
  int pending;
  int items_sent   = 0;
  int sender_idle  = 0;
  int rx_stall     = 0;
  int quiet_cycles = 0;

  wide_string_to_integer_parser_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  wsip_parse_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_stall);
  end

  // ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("tb_wide_string_to_integer_parser_unit: FAIL");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [CHAR_W-1:0] ch, input logic empty,
                           input logic last);
    while ($urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      s_tdata  <= CHAR_W'($urandom_range(16'hffff));
      s_tuser  <= 1'($urandom_range(1));
      s_tlast  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= empty;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // write the base only once the block has drained, then pick the idle mix
  task automatic set_base(input logic [BASE_W-1:0] b, input int mode);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wdata <= b;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (mode)
      1:       begin sender_idle = 74; rx_stall = 0;  end
      2:       begin sender_idle = 0;  rx_stall = 74; end
      3:       begin sender_idle = 16; rx_stall = 16; end
      default: begin sender_idle = 0;  rx_stall = 0;  end
    endcase
  endtask

  // a byte, sometimes carried in a wide character with a nonzero high byte
  function automatic logic [CHAR_W-1:0] widen(input logic [7:0] b);
    logic [7:0] hi;
    hi = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00;
    return {hi, b};
  endfunction

  function automatic logic [CHAR_W-1:0] mixed_case(input logic [7:0] lc);
    return widen($urandom_range(1) ? lc - CASE_OFS : lc);
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input int d);
    if (d < 10) begin
      return widen(CH_0 + 8'(d));
    end
    return mixed_case(CH_A + 8'(d - 10));
  endfunction

  function automatic logic [CHAR_W-1:0] noise_char();
    if ($urandom_range(1)) begin
      return CHAR_W'($urandom_range(16'hffff));
    end
    return widen(8'($urandom_range(8'h20, 8'h7a)));
  endfunction

  // something that ends the digit run: out-of-range digit or a non-digit
  function automatic logic [CHAR_W-1:0] stop_char(input int dbase);
    if (dbase < 16 && $urandom_range(1)) begin
      return digit_char($urandom_range(15, dbase));
    end
    case ($urandom_range(5))
      0:       return widen(8'h20);
      1:       return mixed_case(8'h67);
      2:       return widen(CH_MINUS);
      3:       return widen(CH_PLUS);
      4:       return mixed_case(CH_X);
      default: return widen(8'h2e);
    endcase
  endfunction

  task automatic send_random_string(input logic [BASE_W-1:0] base);
    logic [CHAR_W-1:0] chars[$];
    int                kind;
    int                roll;
    int                n;
    int                dbase;
    logic              end_marker;
    kind = $urandom_range(99);
    if (kind < 4) begin
      send_beat(CHAR_W'($urandom_range(16'hffff)), 1'b1, 1'b1);
      return;
    end
    if (kind < 12) begin
      n = $urandom_range(6, 1);
      repeat (n) chars.push_back(noise_char());
    end else begin
      roll = $urandom_range(99);
      if (roll < 25) begin
        chars.push_back(widen(CH_MINUS));
      end else if (roll < 40) begin
        chars.push_back(widen(CH_PLUS));
      end
      roll  = $urandom_range(99);
      dbase = base;
      if (base == BASE_AUTO) begin
        if (roll < 25) begin
          chars.push_back(mixed_case(CH_X));
          dbase = 16;
        end else if (roll < 40) begin
          chars.push_back(mixed_case(CH_O));
          dbase = 8;
        end else if (roll < 55) begin
          chars.push_back(mixed_case(CH_B));
          dbase = 2;
        end else begin
          dbase = 10;
        end
      end else begin
        if (!(base == BASE_2 || base == BASE_8 || base == BASE_10 || base == BASE_16)) begin
          dbase = 16;
        end
        // prefix letters mean nothing with a fixed base
        if (roll < 10) begin
          case ($urandom_range(2))
            0:       chars.push_back(mixed_case(CH_X));
            1:       chars.push_back(mixed_case(CH_O));
            default: chars.push_back(mixed_case(CH_B));
          endcase
        end
      end
      roll = $urandom_range(99);
      n = (roll < 5) ? 0 : (roll < 20) ? $urandom_range(34, 11) : $urandom_range(10, 1);
      repeat (n) chars.push_back(digit_char($urandom_range(dbase - 1)));
      roll = $urandom_range(99);
      if (roll < 20) begin
        chars.push_back('0);
        repeat ($urandom_range(3)) chars.push_back(noise_char());
      end else if (roll < 40) begin
        chars.push_back(stop_char(dbase));
        repeat ($urandom_range(3)) chars.push_back(noise_char());
      end
    end
    if (chars.size() == 0) begin
      send_beat(CHAR_W'($urandom_range(16'hffff)), 1'b1, 1'b1);
      return;
    end
    end_marker = ($urandom_range(9) == 0);
    foreach (chars[i]) begin
      if ($urandom_range(9) == 0) begin
        send_beat(CHAR_W'($urandom_range(16'hffff)), 1'b1, 1'b0);
      end
      send_beat(chars[i], 1'b0, !end_marker && (i == chars.size() - 1));
    end
    if (end_marker) begin
      send_beat(CHAR_W'($urandom_range(16'hffff)), 1'b1, 1'b1);
    end
  endtask

  function automatic logic [BASE_W-1:0] segment_base(input int seg);
    case (seg)
      0:       return BASE_10;
      1:       return BASE_16;
      2:       return BASE_AUTO;
      3:       return BASE_2;
      4:       return BASE_8;
      5:       return 5'd15;
      6:       return BASE_AUTO;
      7:       return BASE_16;
      8:       return 5'd1;
      9:       return BASE_AUTO;
      10:      return BASE_10;
      default: return BASE_AUTO;
    endcase
  endfunction

  initial begin
    int target;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    set_base(BASE_AUTO, 0);
    // empty string
    send_beat(16'hffff, 1'b1, 1'b1);
    // sign only, auto base never resolved
    send_beat(widen(CH_MINUS), 1'b0, 1'b0);
    send_beat(16'h0000, 1'b1, 1'b1);
    // NUL where the prefix would be
    send_beat({8'h00, CH_PLUS}, 1'b0, 1'b0);
    send_beat(16'h0000, 1'b0, 1'b1);
    // wide character with a zero low byte in prefix position
    send_beat({8'h00, CH_PLUS}, 1'b0, 1'b0);
    send_beat(16'h1200, 1'b0, 1'b1);
    // upper-case hex prefix, then mixed-case digits
    send_beat({8'h00, 8'h58}, 1'b0, 1'b0);
    send_beat({8'hff, 8'h46}, 1'b0, 1'b0);
    send_beat({8'h80, 8'h66}, 1'b0, 1'b1);
    // octal with an empty step inside, stopped by an out-of-range digit
    send_beat({8'h00, CH_O}, 1'b0, 1'b0);
    send_beat(16'h5555, 1'b1, 1'b0);
    send_beat({8'h00, 8'h37}, 1'b0, 1'b0);
    send_beat({8'h00, 8'h38}, 1'b0, 1'b1);
    // binary stopped by a 2
    send_beat({8'h00, CH_B}, 1'b0, 1'b0);
    send_beat({8'h00, 8'h31}, 1'b0, 1'b0);
    send_beat({8'h00, 8'h30}, 1'b0, 1'b0);
    send_beat({8'h00, 8'h32}, 1'b0, 1'b1);
    // negative decimal whose second digit rides on a wide character
    send_beat({8'h00, CH_MINUS}, 1'b0, 1'b0);
    send_beat({8'h00, 8'h31}, 1'b0, 1'b0);
    send_beat({8'hff, 8'h31}, 1'b0, 1'b1);
    // string ended by an empty step
    send_beat({8'h00, 8'h35}, 1'b0, 1'b0);
    send_beat(16'h0000, 1'b1, 1'b1);

    // prefix letter is just a digit with a fixed base
    set_base(BASE_16, 0);
    send_beat({8'h00, CH_B}, 1'b0, 1'b1);
    // unusable fixed base
    set_base(5'd7, 0);
    send_beat({8'h00, 8'h31}, 1'b0, 1'b1);

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      set_base(segment_base(seg), seg % 4);
      target = items_sent + SEG_ITEMS;
      while (items_sent < target) send_random_string(segment_base(seg));
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_wide_string_to_integer_parser_unit: PASS");
    end else begin
      $display("tb_wide_string_to_integer_parser_unit: FAIL");
    end
    $finish;
  end

endmodule

@@ wide_string_to_integer_parser_unit.f @@
design/wsip_pkg.sv
design/wsip_front.sv
design/wsip_queue.sv
design/wsip_back.sv
design/wide_string_to_integer_parser_unit.sv
sim/wsip_parse_checker.sv
sim/tb_wide_string_to_integer_parser_unit.sv
